// ----- design/tpa_pkg.sv -----
package tpa_pkg;

   localparam int unsigned COORD_BITS_DEFAULT = 32;
   localparam int unsigned IO_COORD_WIDTH     = 32;
   localparam int unsigned REQ_TDATA_WIDTH    = 2 * IO_COORD_WIDTH;
   localparam int unsigned REQ_TUSER_WIDTH    = 3;
   localparam int unsigned RSP_TDATA_WIDTH    = 6 * IO_COORD_WIDTH;
   localparam int unsigned RSP_TUSER_WIDTH    = 1;

   // strip and fan hold two corners; a list emits on its third vertex
   localparam int unsigned STASH_DEPTH    = 2;
   localparam int unsigned STASH_IDX_BITS = 1;
   localparam int unsigned COUNT_BITS     = 2;

   typedef enum logic {
      OP_BEGIN  = 1'b0,
      OP_VERTEX = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_LIST    = 2'd0,
      MODE_STRIP   = 2'd1,
      MODE_FAN     = 2'd2,
      MODE_UNKNOWN = 2'd3
   } prim_mode_type;

   typedef struct packed {
      op_type                            operation;
      prim_mode_type                     prim_type;
      logic signed [IO_COORD_WIDTH-1:0]  vert_x;
      logic signed [IO_COORD_WIDTH-1:0]  vert_y;
   } item_type;

   typedef struct packed {
      logic signed [IO_COORD_WIDTH-1:0]  tri_ax;
      logic signed [IO_COORD_WIDTH-1:0]  tri_ay;
      logic signed [IO_COORD_WIDTH-1:0]  tri_bx;
      logic signed [IO_COORD_WIDTH-1:0]  tri_by;
      logic signed [IO_COORD_WIDTH-1:0]  tri_cx;
      logic signed [IO_COORD_WIDTH-1:0]  tri_cy;
      logic                              bad_type;
   } result_type;

endpackage

// ----- design/tpa_in_stage.sv -----
module tpa_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tpa_pkg::item_type  item_in,
   input  logic               advance,
   output logic               item_valid,
   output tpa_pkg::item_type  item
);
   import tpa_pkg::*;

   logic     item_valid_ff;
   logic     item_valid_in;
   item_type item_ff;

   assign req_ready     = !reset && (!item_valid_ff || advance);
   assign item_valid_in = req_ready ? req_valid : item_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// ----- design/tpa_assemble.sv -----
module tpa_assemble #(
   parameter int unsigned COORD_BITS = tpa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tpa_pkg::item_type    item,
   output logic                 result_valid,
   output tpa_pkg::result_type  result
);
   import tpa_pkg::*;

   prim_mode_type                mode_ff, mode_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [COORD_BITS-1:0] sx_ff [STASH_DEPTH];
   logic signed [COORD_BITS-1:0] sy_ff [STASH_DEPTH];
   logic signed [COORD_BITS-1:0] sx_in [STASH_DEPTH];
   logic signed [COORD_BITS-1:0] sy_in [STASH_DEPTH];
   logic signed [COORD_BITS-1:0] vx, vy;
   logic [STASH_IDX_BITS-1:0]    slot;

   // coordinates live in COORD_BITS, sign extended or cut
   assign vx   = COORD_BITS'(item.vert_x);
   assign vy   = COORD_BITS'(item.vert_y);
   assign slot = count_ff[STASH_IDX_BITS-1:0];

   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      result_valid = 1'b0;
      result       = '0;
      if (step) begin
         if (item.operation == OP_BEGIN) begin
            mode_in  = item.prim_type;
            count_in = '0;
         end else begin
            case (mode_ff)
               MODE_STRIP, MODE_FAN: begin
                  if (count_ff < COUNT_BITS'(STASH_DEPTH)) begin
                     sx_in[slot] = vx;
                     sy_in[slot] = vy;
                     count_in    = count_ff + COUNT_BITS'(1);
                  end else begin
                     result_valid  = 1'b1;
                     result.tri_ax = IO_COORD_WIDTH'(sx_ff[0]);
                     result.tri_ay = IO_COORD_WIDTH'(sy_ff[0]);
                     result.tri_bx = IO_COORD_WIDTH'(sx_ff[1]);
                     result.tri_by = IO_COORD_WIDTH'(sy_ff[1]);
                     result.tri_cx = IO_COORD_WIDTH'(vx);
                     result.tri_cy = IO_COORD_WIDTH'(vy);
                     if (mode_ff == MODE_STRIP) begin
                        sx_in[0] = sx_ff[1];
                        sy_in[0] = sy_ff[1];
                     end
                     sx_in[1] = vx;
                     sy_in[1] = vy;
                  end
               end
               MODE_LIST: begin
                  if (count_ff >= COUNT_BITS'(STASH_DEPTH)) begin
                     // third corner goes straight out
                     result_valid  = 1'b1;
                     result.tri_ax = IO_COORD_WIDTH'(sx_ff[0]);
                     result.tri_ay = IO_COORD_WIDTH'(sy_ff[0]);
                     result.tri_bx = IO_COORD_WIDTH'(sx_ff[1]);
                     result.tri_by = IO_COORD_WIDTH'(sy_ff[1]);
                     result.tri_cx = IO_COORD_WIDTH'(vx);
                     result.tri_cy = IO_COORD_WIDTH'(vy);
                     count_in      = '0;
                  end else begin
                     sx_in[slot] = vx;
                     sy_in[slot] = vy;
                     count_in    = count_ff + COUNT_BITS'(1);
                  end
               end
               default: begin
                  result_valid    = 1'b1;
                  result.bad_type = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_UNKNOWN;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

endmodule

// ----- design/tpa_out_stage.sv -----
module tpa_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tpa_pkg::result_type  result_in,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output tpa_pkg::result_type  result,
   output logic                 can_take
);
   import tpa_pkg::*;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type result_ff;

   assign can_take     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

// ----- design/triangle_primitive_assembler_core.sv -----
// Results pass the in_stage and out_stage registers. Throughput: one item
// per clock while rsp is not stalled, set by the single stash update per
// item in tpa_assemble; rsp_tready reaches req_tready combinationally.
// Reset (synchronous, active high) empties both registers, sets the
// primitive mode to unknown and the stash count to zero.
module triangle_primitive_assembler_core #(
   parameter int unsigned COORD_BITS = tpa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // vert_x, vert_y
   input  logic [tpa_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // operation, prim_type
   input  logic [tpa_pkg::REQ_TUSER_WIDTH-1:0]  req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy
   output logic [tpa_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // bad_type
   output logic [tpa_pkg::RSP_TUSER_WIDTH-1:0]  rsp_tuser
);
   import tpa_pkg::*;

   item_type   item_in, item;
   logic       item_valid;
   logic       advance;
   logic       step;
   logic       result_valid;
   result_type result_next, result;

   assign item_in.operation = op_type'(req_tuser[0]);
   assign item_in.prim_type = prim_mode_type'(req_tuser[2:1]);
   assign item_in.vert_x    = req_tdata[IO_COORD_WIDTH-1:0];
   assign item_in.vert_y    = req_tdata[2*IO_COORD_WIDTH-1:IO_COORD_WIDTH];

   assign step = item_valid && advance;

   tpa_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .item_in    (item_in),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tpa_assemble #(
      .COORD_BITS (COORD_BITS)
   ) u_assemble (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (item),
      .result_valid (result_valid),
      .result       (result_next)
   );

   tpa_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .result_in (result_next),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .result    (result),
      .can_take  (advance)
   );

   assign rsp_tdata = {result.tri_cy, result.tri_cx, result.tri_by,
                       result.tri_bx, result.tri_ay, result.tri_ax};
   assign rsp_tuser = result.bad_type;

endmodule

// ----- design/tpa_checker.sv -----
module tpa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [tpa_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   input logic [tpa_pkg::RSP_TUSER_WIDTH-1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_bad_no_corners: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("bad type item carries corners");

   // a fresh result needs an accepted item that passed the input and result registers
   a_rise_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without accepted item");

endmodule

bind triangle_primitive_assembler_core tpa_checker u_tpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
